// ===== src/lzwgif_pkg.sv =====
package lzwgif_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] stream_byte;
    logic       start_frame;
  } in_item_t;

  typedef struct packed {
    logic       byte_taken;
    logic       pixel_valid;
    logic [7:0] pixel;
    logic       frame_done;
  } out_item_t;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic REQ_FEED = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  localparam int ACC_BITS = 20;

endpackage

// ===== src/lzw_gif_frame_decoder.sv =====
// Sequential LZW decoder for GIF-style frame data, one request at a time.
// A feed runs S_CHECK then S_RESP; a pull with pixels stacked first reads the stack in
// S_POP. Each code decoded is another S_CHECK pass; a dictionary walk takes S_WALK and
// S_PUSH per entry and ends in S_WALK, as the prefix/suffix memory gives one entry per
// read cycle. The next request is taken in the cycle after the response is accepted.
// Synchronous active-high reset clears all control state; the memories are not cleared.
module lzw_gif_frame_decoder #(
  parameter int TABLE_ENTRIES  = 4096,
  parameter int MAX_CODE_WIDTH = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  lzwgif_pkg::in_item_t    in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output lzwgif_pkg::out_item_t   out_data
);

  // Widths derived from the table size.  CW holds a code; NW holds a count
  // up to and including TABLE_ENTRIES.
  localparam int CW = $clog2(TABLE_ENTRIES);
  localparam int NW = CW + 1;
  localparam int AW = lzwgif_pkg::ACC_BITS;
  localparam int WW = $clog2(MAX_CODE_WIDTH + 1);
  localparam int LW = MAX_CODE_WIDTH + 1;
  localparam logic [NW-1:0] TABLE_FULL = NW'(TABLE_ENTRIES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;  // decide whether another code is decoded
  localparam logic [2:0] S_WALK  = 3'd2;  // read of the chain entry under way
  localparam logic [2:0] S_PUSH  = 3'd3;  // chain entry data available
  localparam logic [2:0] S_POP   = 3'd4;  // stack read under way
  localparam logic [2:0] S_RESP  = 3'd5;  // response waiting to be taken

  logic [2:0]          state;
  logic [3:0]          root_bits;
  logic [WW-1:0]       code_width;
  logic [LW:0]         width_limit;
  logic [NW-1:0]       next_free_code;
  logic                literal_pending;
  logic [CW-1:0]       previous_code;
  logic [7:0]          first_char;
  logic [AW-1:0]       bit_accumulator;
  logic [4:0]          bits_held;
  logic [7:0]          block_bytes_left;
  logic [1:0]          stream_phase;
  logic [NW-1:0]       stack_count;

  // Walk bookkeeping for the code under decode.
  logic [NW-1:0]       walk_cur;
  logic [NW-1:0]       walk_eff;
  logic                walk_kwk;

  // Response register.
  lzwgif_pkg::out_item_t resp;

  // Memories: suffix and prefix are kept side by side in one dictionary word.
  logic [CW+7:0]       dict_mem [TABLE_ENTRIES];
  logic [7:0]          stack_mem [TABLE_ENTRIES];
  logic [CW+7:0]       dict_rd;
  logic [7:0]          stack_rd;
  logic                dict_we;
  logic [CW-1:0]       dict_wa;
  logic [CW+7:0]       dict_wd;
  logic [CW-1:0]       dict_ra;
  logic                stk_we;
  logic [CW-1:0]       stk_wa;
  logic [7:0]          stk_wd;
  logic [CW-1:0]       stk_ra;

  always_ff @(posedge clk) begin
    if (dict_we) begin
      dict_mem[dict_wa] <= dict_wd;
    end
    dict_rd <= dict_mem[dict_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    stack_rd <= stack_mem[stk_ra];
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);
  assign out_data  = resp;

  // Derived values.
  logic [NW-1:0] clear_code;
  logic [NW-1:0] code_mask;
  logic [NW-1:0] code_now;
  logic          can_decode;
  logic          stack_room;

  always_comb begin
    clear_code = NW'(1) << root_bits;
    code_mask  = (NW'(1) << code_width) - NW'(1);
    code_now   = NW'(bit_accumulator) & code_mask;
    can_decode = ((stream_phase == lzwgif_pkg::PH_COUNT) ||
                  (stream_phase == lzwgif_pkg::PH_DATA)) &&
                 (stack_count == '0) && ({3'b0, bits_held} >= 8'(code_width)) &&
                 (code_width != '0);
    stack_room = (stack_count < TABLE_FULL);
  end

  // The chain walk continues while the current code names a dictionary entry.
  logic walk_more;
  assign walk_more = (walk_cur >= clear_code + NW'(2)) && (walk_cur < TABLE_FULL) &&
                     stack_room;

  // Finishing a code: push the root, add an entry, update width.
  logic [7:0]   fin_root;
  logic         fin_add;
  logic [NW-1:0] fin_nfc;
  assign fin_root = walk_cur[7:0];
  assign fin_add  = ({1'b0, next_free_code} < (LW+1)'(width_limit)) &&
                    (next_free_code < TABLE_FULL);
  assign fin_nfc  = fin_add ? next_free_code + NW'(1) : next_free_code;

  always_comb begin
    dict_we = 1'b0;
    dict_wa = next_free_code[CW-1:0];
    dict_wd = {fin_root, previous_code};
    dict_ra = walk_cur[CW-1:0];
    stk_we  = 1'b0;
    stk_wa  = stack_count[CW-1:0];
    stk_wd  = fin_root;
    stk_ra  = stack_count[CW-1:0] - CW'(1);
    unique case (state)
      S_CHECK: begin
        if (can_decode && (code_now != clear_code) && (code_now != clear_code + NW'(1))
            && stack_room) begin
          if (literal_pending) begin
            stk_we = 1'b1;
            stk_wd = code_now[7:0] & (clear_code[7:0] - 8'd1);
          end else if (code_now >= next_free_code) begin
            stk_we = 1'b1;
            stk_wd = first_char;
          end
        end
      end
      S_WALK: begin
        if (!walk_more) begin
          stk_we  = stack_room;
          dict_we = fin_add;
        end
      end
      S_PUSH: begin
        stk_we = stack_room;
        stk_wd = dict_rd[CW+7:CW];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      root_bits        <= '0;
      code_width       <= '0;
      width_limit      <= '0;
      next_free_code   <= '0;
      literal_pending  <= 1'b0;
      previous_code    <= '0;
      first_char       <= '0;
      bit_accumulator  <= '0;
      bits_held        <= '0;
      block_bytes_left <= '0;
      stream_phase     <= lzwgif_pkg::PH_IDLE;
      stack_count      <= '0;
      resp             <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.req_type == lzwgif_pkg::REQ_FEED) begin
              if (in_data.start_frame) begin
                logic [3:0] rb;
                rb = (in_data.stream_byte == 8'd0) ? 4'd1 :
                     (in_data.stream_byte > 8'd8) ? 4'd8 : in_data.stream_byte[3:0];
                root_bits        <= rb;
                code_width       <= WW'(rb) + WW'(1);
                width_limit      <= (LW+1)'(2) << rb;
                next_free_code   <= (NW'(1) << rb) + NW'(2);
                literal_pending  <= 1'b1;
                previous_code    <= '0;
                first_char       <= '0;
                bit_accumulator  <= '0;
                bits_held        <= '0;
                block_bytes_left <= '0;
                stack_count      <= '0;
                stream_phase     <= lzwgif_pkg::PH_COUNT;
                resp.byte_taken  <= 1'b1;
                state            <= S_CHECK;
              end else if (stack_count == '0) begin
                resp.byte_taken <= 1'b1;
                state           <= S_CHECK;
                if (stream_phase == lzwgif_pkg::PH_COUNT) begin
                  block_bytes_left <= in_data.stream_byte;
                  stream_phase <= (in_data.stream_byte != 8'd0) ? lzwgif_pkg::PH_DATA
                                                                : lzwgif_pkg::PH_DONE;
                end else if (stream_phase == lzwgif_pkg::PH_DATA) begin
                  if (bits_held < 5'd13) begin
                    bit_accumulator <= bit_accumulator |
                                       (AW'(in_data.stream_byte) << bits_held);
                    bits_held       <= bits_held + 5'd8;
                  end
                  block_bytes_left <= block_bytes_left - 8'd1;
                  if (block_bytes_left == 8'd1) begin
                    stream_phase <= lzwgif_pkg::PH_COUNT;
                  end
                end
              end else begin
                state <= S_CHECK;
              end
            end else if (stack_count != '0) begin
              stack_count       <= stack_count - NW'(1);
              resp.pixel_valid  <= 1'b1;
              state             <= S_POP;
            end else begin
              state <= S_CHECK;
            end
          end
        end

        S_POP: begin
          resp.pixel <= stack_rd;
          state      <= S_CHECK;
        end

        S_CHECK: begin
          if (can_decode) begin
            bit_accumulator <= bit_accumulator >> code_width;
            bits_held       <= bits_held - 5'(code_width);
            if (code_now == clear_code) begin
              code_width      <= WW'(root_bits) + WW'(1);
              width_limit     <= (LW+1)'(2) << root_bits;
              next_free_code  <= clear_code + NW'(2);
              literal_pending <= 1'b1;
            end else if (code_now == clear_code + NW'(1)) begin
              stream_phase <= lzwgif_pkg::PH_DONE;
            end else if (literal_pending) begin
              logic [7:0] lit;
              lit = code_now[7:0] & (clear_code[7:0] - 8'd1);
              if (stack_room) stack_count <= stack_count + NW'(1);
              previous_code   <= CW'(lit);
              first_char      <= lit;
              literal_pending <= 1'b0;
            end else if (code_now >= next_free_code) begin
              if (stack_room) stack_count <= stack_count + NW'(1);
              walk_eff <= next_free_code;
              walk_kwk <= 1'b1;
              walk_cur <= NW'(previous_code);
              state    <= S_WALK;
            end else begin
              walk_eff <= code_now;
              walk_kwk <= 1'b0;
              walk_cur <= code_now;
              state    <= S_WALK;
            end
          end else begin
            resp.frame_done <= (stream_phase == lzwgif_pkg::PH_DONE) && (stack_count == '0);
            state           <= S_RESP;
          end
        end

        S_WALK: begin
          if (walk_more) begin
            state <= S_PUSH;
          end else begin
            if (stack_room) stack_count <= stack_count + NW'(1);
            next_free_code <= fin_nfc;
            if (!walk_kwk || fin_add) previous_code <= walk_eff[CW-1:0];
            first_char <= fin_root;
            if (((LW+1)'(width_limit) <= (LW+1)'(fin_nfc)) &&
                (code_width < WW'(MAX_CODE_WIDTH))) begin
              code_width  <= code_width + WW'(1);
              width_limit <= width_limit << 1;
            end
            state <= S_CHECK;
          end
        end

        S_PUSH: begin
          if (stack_room) stack_count <= stack_count + NW'(1);
          walk_cur <= NW'(dict_rd[CW-1:0]);
          state    <= S_WALK;
        end

        S_RESP: begin
          // The response register is cleared as it leaves, ready for the next request.
          if (out_ready) begin
            resp  <= '0;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
